// ===== hdl/drot_pkg.sv =====
package drot_pkg;

    // item field widths
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned SENSE_W   = 3;
    localparam int unsigned DEB_W     = 16;
    localparam int unsigned HOLD_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;

    // stream payload widths, rounded up to whole bytes
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ACTIVE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_ACTIVE_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME          = 2'd3;

    // register values after reset
    localparam logic              RST_SENSOR_ACTIVE_HIGH = 1'b0;
    localparam logic              RST_RELAY_ACTIVE_HIGH  = 1'b1;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE_TIME      = 16'd40;
    localparam logic [HOLD_W-1:0] RST_HOLD_TIME          = 24'd2000;

    // configuration seen by every channel
    typedef struct packed {
        logic              sensor_active_high;
        logic              relay_active_high;
        logic [DEB_W-1:0]  debounce_time;
        logic [HOLD_W-1:0] hold_time;
    } t_cfg;

    // per channel result of one sample
    typedef struct packed {
        logic level;
        logic opened;
        logic closed;
    } t_chan_evt;

endpackage

// ===== hdl/drot_channel.sv =====
module drot_channel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [drot_pkg::NOW_W-1:0]        i_now,
    input  logic                              i_raw,
    input  drot_pkg::t_cfg                    i_cfg,
    output drot_pkg::t_chan_evt               o_evt
);

    logic                       r_last_raw;
    logic                       r_stable;
    logic                       r_is_open;
    logic                       r_fired;
    logic [drot_pkg::NOW_W-1:0] r_change_stamp;
    logic [drot_pkg::NOW_W-1:0] r_open_stamp;

    logic                       n_last_raw;
    logic                       n_stable;
    logic                       n_is_open;
    logic                       n_fired;
    logic [drot_pkg::NOW_W-1:0] n_change_stamp;
    logic [drot_pkg::NOW_W-1:0] n_open_stamp;

    logic [drot_pkg::NOW_W-1:0] deb_age;
    logic [drot_pkg::NOW_W-1:0] open_age;
    logic                       detect;
    logic                       open_fire;
    logic                       open_mid;
    logic                       close_fire;

    // debounce: a change restarts the age, a settled level becomes stable
    always_comb begin
        n_last_raw     = i_raw;
        n_change_stamp = (i_raw != r_last_raw) ? i_now : r_change_stamp;
        deb_age        = i_now - n_change_stamp;
        n_stable       = (deb_age >= {{(drot_pkg::NOW_W-drot_pkg::DEB_W){1'b0}},
                                      i_cfg.debounce_time}) ? i_raw : r_stable;
    end

    // one-shot: open on fresh detection, close after the hold time
    always_comb begin
        detect       = (n_stable == i_cfg.sensor_active_high);
        open_fire    = detect && !r_fired;
        open_mid     = open_fire || r_is_open;
        n_open_stamp = open_fire ? i_now : r_open_stamp;
        open_age     = i_now - n_open_stamp;
        close_fire   = open_mid && (open_age >= {{(drot_pkg::NOW_W-drot_pkg::HOLD_W){1'b0}},
                                                 i_cfg.hold_time});
        n_is_open    = open_mid && !close_fire;
        n_fired      = detect;
    end

    // pin level and event flags for this sample
    always_comb begin
        o_evt.level  = n_is_open ? !i_cfg.relay_active_high : i_cfg.relay_active_high;
        o_evt.opened = open_fire;
        o_evt.closed = close_fire;
    end

    // channel state, advanced once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b0;
            r_stable       <= 1'b0;
            r_is_open      <= 1'b0;
            r_fired        <= 1'b0;
            r_change_stamp <= '0;
            r_open_stamp   <= '0;
        end else if (i_en) begin
            r_last_raw     <= n_last_raw;
            r_stable       <= n_stable;
            r_is_open      <= n_is_open;
            r_fired        <= n_fired;
            r_change_stamp <= n_change_stamp;
            r_open_stamp   <= n_open_stamp;
        end
    end

endmodule

// ===== hdl/debounced_oneshot_relay_timer.sv =====
// path: an accepted request passes the input register, then the result register
// holding the channel outputs, before it leaves as a result
// throughput: one request per cycle unless a stalled result holds it back; the
// per channel subtract and compare between the two registers is the only work path
// reset: synchronous active low i_rst_n empties both registers, clears all
// channel state (every relay closed) and loads the register defaults
module debounced_oneshot_relay_timer #(
    parameter int unsigned CHANNELS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms [31:0], raw_sensors [34:32], zero fill [39:35]
    input  logic [drot_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // relay_levels [2:0], open_events [5:3], close_events [8:6], zero fill [15:9]
    output logic [drot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [drot_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [drot_pkg::CFG_DAT_W-1:0]      i_cfg_wdata
);

    localparam int unsigned FW = drot_pkg::SENSE_W;

    drot_pkg::t_cfg               r_cfg;
    logic                         r_in_valid;
    logic [drot_pkg::NOW_W-1:0]   r_in_now;
    logic [FW-1:0]                r_in_raw;
    logic                         r_out_valid;
    logic [FW-1:0]                r_out_levels;
    logic [FW-1:0]                r_out_opened;
    logic [FW-1:0]                r_out_closed;

    logic                         fire;
    logic                         take;
    drot_pkg::t_chan_evt          chan_evt [CHANNELS];
    logic [FW-1:0]                n_levels;
    logic [FW-1:0]                n_opened;
    logic [FW-1:0]                n_closed;

    // handshake: process when the result register is free or being drained
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign take          = s_axis_tvalid && s_axis_tready;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_active_high <= drot_pkg::RST_SENSOR_ACTIVE_HIGH;
            r_cfg.relay_active_high  <= drot_pkg::RST_RELAY_ACTIVE_HIGH;
            r_cfg.debounce_time      <= drot_pkg::RST_DEBOUNCE_TIME;
            r_cfg.hold_time          <= drot_pkg::RST_HOLD_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                drot_pkg::REG_SENSOR_ACTIVE_HIGH: r_cfg.sensor_active_high <= i_cfg_wdata[0];
                drot_pkg::REG_RELAY_ACTIVE_HIGH:  r_cfg.relay_active_high  <= i_cfg_wdata[0];
                drot_pkg::REG_DEBOUNCE_TIME:
                    r_cfg.debounce_time <= i_cfg_wdata[drot_pkg::DEB_W-1:0];
                drot_pkg::REG_HOLD_TIME:
                    r_cfg.hold_time <= i_cfg_wdata[drot_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_now <= s_axis_tdata[drot_pkg::NOW_W-1:0];
            r_in_raw <= s_axis_tdata[drot_pkg::NOW_W +: FW];
        end
    end

    // channel datapaths; channels past the field width see a low raw level
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        logic raw_bit;
        if (g < FW) begin : g_raw
            assign raw_bit = r_in_raw[g];
        end else begin : g_zero
            assign raw_bit = 1'b0;
        end

        drot_channel u_channel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (fire),
            .i_now   (r_in_now),
            .i_raw   (raw_bit),
            .i_cfg   (r_cfg),
            .o_evt   (chan_evt[g])
        );
    end

    // gather the visible channels into the result fields
    for (genvar j = 0; j < FW; j++) begin : g_out
        if (j < CHANNELS) begin : g_used
            assign n_levels[j] = chan_evt[j].level;
            assign n_opened[j] = chan_evt[j].opened;
            assign n_closed[j] = chan_evt[j].closed;
        end else begin : g_unused
            assign n_levels[j] = 1'b0;
            assign n_opened[j] = 1'b0;
            assign n_closed[j] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_levels <= n_levels;
            r_out_opened <= n_opened;
            r_out_closed <= n_closed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(drot_pkg::OUT_TDATA_W - 3*FW){1'b0}},
                            r_out_closed, r_out_opened, r_out_levels};

endmodule

// ===== hdl/drot_checker.sv =====
module drot_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [drot_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a stalled result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

    // fill bits above the result fields stay zero
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[drot_pkg::OUT_TDATA_W-1:9] == '0))
        else $error("result fill bits not zero");

endmodule

bind debounced_oneshot_relay_timer drot_checker u_drot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
